[design/jvcm_pkg.sv]
// Shared types, constants and helper functions of the joystick velocity command mapper.
package jvcm_pkg;

	localparam int AXIS_BITS_DEF       = 16;
	localparam int HOLD_COUNT_BITS_DEF = 8;
	localparam int NUM_BUTTONS_DEF     = 13;

	localparam int GAIN_W     = 12;
	localparam int VEL_W      = 14;
	localparam int STEP_W     = 7;
	localparam int HOLD_CFG_W = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;

	localparam int BTN_WAYPOINT = 3;
	localparam int BTN_LIN_UP   = 4;
	localparam int BTN_ANG_UP   = 5;
	localparam int BTN_LIN_DOWN = 6;
	localparam int BTN_ANG_DOWN = 7;
	localparam int BTN_MODE     = 9;
	localparam int BTN_MUTE     = 12;

	localparam logic [HOLD_CFG_W-1:0] TOGGLE_HOLD_RST   = 8'd20;
	localparam logic [HOLD_CFG_W-1:0] WAYPOINT_HOLD_RST = 8'd50;
	localparam logic [STEP_W-1:0]     GAIN_STEP_RST     = 7'd1;
	localparam logic [GAIN_W-1:0]     LIN_MAX_RST       = 12'd200;
	localparam logic [GAIN_W-1:0]     ANG_MAX_RST       = 12'd2000;
	localparam logic [GAIN_W-1:0]     GAIN_RST          = 12'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOGGLE_HOLD   = 3'd0,
		CFG_WAYPOINT_HOLD = 3'd1,
		CFG_GAIN_STEP     = 3'd2,
		CFG_LIN_MAX       = 3'd3,
		CFG_ANG_MAX       = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic flag;
		logic flag_next;
	} hold_sts_t;

	function automatic logic [GAIN_W-1:0] gain_up(input logic [GAIN_W-1:0] g,
		input logic [STEP_W-1:0] step, input logic [GAIN_W-1:0] max);
		logic [GAIN_W:0] n;
		n = {1'b0, g} + (GAIN_W+1)'(step);
		return (n > {1'b0, max}) ? max : n[GAIN_W-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] gain_down(input logic [GAIN_W-1:0] g,
		input logic [STEP_W-1:0] step);
		logic [GAIN_W-1:0] s;
		s = GAIN_W'(step);
		return (g < s) ? '0 : g - s;
	endfunction

endpackage

[design/jvcm_if.sv]
// Handshake channels for tick requests and command results.
interface jvcm_tick_if #(
	parameter int AXIS_BITS   = jvcm_pkg::AXIS_BITS_DEF,
	parameter int NUM_BUTTONS = jvcm_pkg::NUM_BUTTONS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        joystick_valid;
	logic [NUM_BUTTONS-1:0]      buttons_pressed;
	logic signed [AXIS_BITS-1:0] axis_turn;
	logic signed [AXIS_BITS-1:0] axis_forward;
	logic signed [AXIS_BITS-1:0] axis_tilt_turn;
	logic signed [AXIS_BITS-1:0] axis_tilt_forward;

	modport source (output valid, joystick_valid, buttons_pressed, axis_turn, axis_forward,
		axis_tilt_turn, axis_tilt_forward, input ready);
	modport sink (input valid, joystick_valid, buttons_pressed, axis_turn, axis_forward,
		axis_tilt_turn, axis_tilt_forward, output ready);
endinterface

interface jvcm_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  publish_velocity;
	logic signed [jvcm_pkg::VEL_W-1:0]     linear_velocity;
	logic signed [jvcm_pkg::VEL_W-1:0]     angular_velocity;
	logic                                  waypoint_pulse;
	logic                                  gyro_mode_on;
	logic [jvcm_pkg::GAIN_W-1:0]           linear_gain_now;
	logic [jvcm_pkg::GAIN_W-1:0]           angular_gain_now;

	modport source (output valid, publish_velocity, linear_velocity, angular_velocity,
		waypoint_pulse, gyro_mode_on, linear_gain_now, angular_gain_now, input ready);
	modport sink (input valid, publish_velocity, linear_velocity, angular_velocity,
		waypoint_pulse, gyro_mode_on, linear_gain_now, angular_gain_now, output ready);
endinterface

[design/joystick_velocity_command_mapper.sv]
// Top level: a tick request is registered, mapped in one pass and held in a result register.
// An accepted tick request passes through the input register and then the result register to the output.
// Throughput: one tick per cycle; a stalled result stops the input stage only once it is full.
// The path from the input register to the result register is the gain step and one multiplier.
// Reset clears gains to 20, all hold, mute, mode and waypoint state and the stage valid bits,
// and loads the configuration registers with their default values.
module joystick_velocity_command_mapper #(
	parameter int AXIS_BITS       = jvcm_pkg::AXIS_BITS_DEF,
	parameter int HOLD_COUNT_BITS = jvcm_pkg::HOLD_COUNT_BITS_DEF,
	parameter int NUM_BUTTONS     = jvcm_pkg::NUM_BUTTONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	jvcm_tick_if.sink                         tick,
	jvcm_cmd_if.source                        cmd,
	input  logic                              cfg_we,
	input  logic [jvcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jvcm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import jvcm_pkg::*;

	localparam int WK = (HOLD_COUNT_BITS > HOLD_CFG_W) ? HOLD_COUNT_BITS : HOLD_CFG_W;

	// Configuration
	logic [HOLD_CFG_W-1:0] toggle_hold_q, waypoint_hold_q;
	logic [STEP_W-1:0]     gain_step_q;
	logic [GAIN_W-1:0]     lin_max_q, ang_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_hold_q   <= TOGGLE_HOLD_RST;
			waypoint_hold_q <= WAYPOINT_HOLD_RST;
			gain_step_q     <= GAIN_STEP_RST;
			lin_max_q       <= LIN_MAX_RST;
			ang_max_q       <= ANG_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TOGGLE_HOLD:   toggle_hold_q   <= cfg_wdata[HOLD_CFG_W-1:0];
				CFG_WAYPOINT_HOLD: waypoint_hold_q <= cfg_wdata[HOLD_CFG_W-1:0];
				CFG_GAIN_STEP:     gain_step_q     <= cfg_wdata[STEP_W-1:0];
				CFG_LIN_MAX:       lin_max_q       <= cfg_wdata[GAIN_W-1:0];
				CFG_ANG_MAX:       ang_max_q       <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage
	logic                        valid_s1;
	logic                        jv_s1;
	logic [NUM_BUTTONS-1:0]      btn_s1;
	logic signed [AXIS_BITS-1:0] turn_s1, fwd_s1, tturn_s1, tfwd_s1;
	logic                        adv, upd, in_ready;

	assign adv      = valid_s1 && (!cmd.valid || cmd.ready);
	assign in_ready = !valid_s1 || adv;
	assign tick.ready = in_ready;
	assign upd      = adv && jv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && in_ready) begin
			jv_s1    <= tick.joystick_valid;
			btn_s1   <= tick.buttons_pressed;
			turn_s1  <= tick.axis_turn;
			fwd_s1   <= tick.axis_forward;
			tturn_s1 <= tick.axis_tilt_turn;
			tfwd_s1  <= tick.axis_tilt_forward;
		end
	end

	// Gains
	logic [GAIN_W-1:0] lin_gain_q, ang_gain_q, lin_gain_d, ang_gain_d;

	always_comb begin
		lin_gain_d = lin_gain_q;
		ang_gain_d = ang_gain_q;
		if (btn_s1[BTN_LIN_UP]) begin
			lin_gain_d = gain_up(lin_gain_q, gain_step_q, lin_max_q);
		end else if (btn_s1[BTN_LIN_DOWN]) begin
			lin_gain_d = gain_down(lin_gain_q, gain_step_q);
		end
		if (btn_s1[BTN_ANG_UP]) begin
			ang_gain_d = gain_up(ang_gain_q, gain_step_q, ang_max_q);
		end else if (btn_s1[BTN_ANG_DOWN]) begin
			ang_gain_d = gain_down(ang_gain_q, gain_step_q);
		end
	end

	// Mute and mode qualifiers
	hold_sts_t mute_sts, mode_sts;

	jvcm_hold #(.HOLD_COUNT_BITS(HOLD_COUNT_BITS)) u_mute (
		.clk(clk), .arst_n(arst_n), .en(upd), .btn(btn_s1[BTN_MUTE]),
		.thr(toggle_hold_q), .sts(mute_sts)
	);

	jvcm_hold #(.HOLD_COUNT_BITS(HOLD_COUNT_BITS)) u_mode (
		.clk(clk), .arst_n(arst_n), .en(upd), .btn(btn_s1[BTN_MODE]),
		.thr(toggle_hold_q), .sts(mode_sts)
	);

	// Velocity
	logic signed [VEL_W-1:0] lin_v, ang_v, last_ang_q;

	jvcm_velocity #(.AXIS_BITS(AXIS_BITS)) u_vel (
		.gyro(mode_sts.flag), .axis_turn(turn_s1), .axis_forward(fwd_s1),
		.axis_tilt_turn(tturn_s1), .axis_tilt_forward(tfwd_s1),
		.lin_gain(lin_gain_d), .ang_gain(ang_gain_d), .lin(lin_v), .ang(ang_v)
	);

	// Waypoint: the pulse fires on the tick after the count reaches the threshold.
	logic [HOLD_COUNT_BITS-1:0] wp_count_q;
	logic                       wp_done_q, wp_fire;
	logic                       wp_below;

	assign wp_below = WK'(wp_count_q) < WK'(waypoint_hold_q);
	assign wp_fire  = !wp_done_q && !wp_below;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= GAIN_RST;
			ang_gain_q <= GAIN_RST;
			last_ang_q <= '0;
			wp_count_q <= '0;
			wp_done_q  <= 1'b0;
		end else if (upd) begin
			lin_gain_q <= lin_gain_d;
			ang_gain_q <= ang_gain_d;
			last_ang_q <= ang_v;
			if (!wp_done_q) begin
				if (wp_below) begin
					if (!btn_s1[BTN_WAYPOINT]) begin
						wp_count_q <= '0;
					end else if (wp_count_q != '1) begin
						wp_count_q <= wp_count_q + 1'b1;
					end
				end else begin
					wp_done_q  <= 1'b1;
					wp_count_q <= '0;
				end
			end
		end
	end

	// Result stage
	logic                    valid_s2;
	logic                    pub_s2, wp_s2, gyro_s2;
	logic signed [VEL_W-1:0] lin_s2, ang_s2;
	logic [GAIN_W-1:0]       lin_gain_s2, ang_gain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (cmd.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pub_s2      <= !mute_sts.flag_next;
			gyro_s2     <= mode_sts.flag_next;
			lin_s2      <= jv_s1 ? lin_v : '0;
			ang_s2      <= jv_s1 ? ang_v : last_ang_q;
			wp_s2       <= jv_s1 && wp_fire;
			lin_gain_s2 <= jv_s1 ? lin_gain_d : lin_gain_q;
			ang_gain_s2 <= jv_s1 ? ang_gain_d : ang_gain_q;
		end
	end

	assign cmd.valid            = valid_s2;
	assign cmd.publish_velocity = pub_s2;
	assign cmd.linear_velocity  = lin_s2;
	assign cmd.angular_velocity = ang_s2;
	assign cmd.waypoint_pulse   = wp_s2;
	assign cmd.gyro_mode_on     = gyro_s2;
	assign cmd.linear_gain_now  = lin_gain_s2;
	assign cmd.angular_gain_now = ang_gain_s2;

endmodule

[design/jvcm_hold.sv]
// Hold qualifier that toggles a flag after an armed button hold.
module jvcm_hold #(
	parameter int HOLD_COUNT_BITS = jvcm_pkg::HOLD_COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                btn,
	input  logic [jvcm_pkg::HOLD_CFG_W-1:0]     thr,
	output jvcm_pkg::hold_sts_t                 sts
);
	import jvcm_pkg::*;

	localparam int CW = HOLD_COUNT_BITS + 1;
	localparam int KW = (CW > HOLD_CFG_W) ? CW : HOLD_CFG_W;

	logic [HOLD_COUNT_BITS-1:0] count_q, count_d;
	logic                       armed_q, armed_d;
	logic                       prev_q;
	logic                       flag_q, flag_d;
	logic                       armed_n;
	logic [CW-1:0]              c;

	always_comb begin
		armed_n = armed_q | (prev_q != btn);
		c       = {1'b0, count_q} + CW'(armed_n);
		count_d = count_q;
		armed_d = armed_q;
		flag_d  = flag_q;
		if (en) begin
			armed_d = armed_n;
			if (btn) begin
				if (KW'(c) > KW'(thr)) begin
					flag_d  = ~flag_q;
					count_d = '0;
					armed_d = 1'b0;
				end else begin
					count_d = c[CW-1] ? '1 : c[HOLD_COUNT_BITS-1:0];
				end
			end else begin
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			armed_q <= 1'b0;
			prev_q  <= 1'b0;
			flag_q  <= 1'b0;
		end else if (en) begin
			count_q <= count_d;
			armed_q <= armed_d;
			prev_q  <= btn;
			flag_q  <= flag_d;
		end
	end

	assign sts.flag      = flag_q;
	assign sts.flag_next = flag_d;

endmodule

[design/jvcm_velocity.sv]
// Axis selection, gain scaling and truncation toward zero of the velocity commands.
module jvcm_velocity #(
	parameter int AXIS_BITS = jvcm_pkg::AXIS_BITS_DEF
) (
	input  logic                              gyro,
	input  logic signed [AXIS_BITS-1:0]       axis_turn,
	input  logic signed [AXIS_BITS-1:0]       axis_forward,
	input  logic signed [AXIS_BITS-1:0]       axis_tilt_turn,
	input  logic signed [AXIS_BITS-1:0]       axis_tilt_forward,
	input  logic [jvcm_pkg::GAIN_W-1:0]       lin_gain,
	input  logic [jvcm_pkg::GAIN_W-1:0]       ang_gain,
	output logic signed [jvcm_pkg::VEL_W-1:0] lin,
	output logic signed [jvcm_pkg::VEL_W-1:0] ang
);
	import jvcm_pkg::*;

	localparam int OW = AXIS_BITS + 1;
	localparam int PW = OW + GAIN_W + 1;
	localparam logic signed [OW-1:0] Quarter = {2'b00, 1'b1, {(AXIS_BITS-2){1'b0}}};
	localparam logic signed [PW-1:0] Bias = {{(PW-AXIS_BITS+1){1'b0}}, {(AXIS_BITS-1){1'b1}}};

	logic signed [OW-1:0]     op_lin, op_ang;
	logic signed [GAIN_W:0]   g_lin, g_ang;
	logic signed [PW-1:0]     p_lin, p_ang, a_lin, a_ang, q_lin, q_ang;
	logic signed [VEL_W-1:0]  ang_t;

	always_comb begin
		if (gyro) begin
			op_lin = Quarter - OW'(axis_tilt_forward);
			op_ang = -OW'(axis_tilt_turn);
		end else begin
			op_lin = OW'(axis_forward);
			op_ang = OW'(axis_turn);
		end
		g_lin = $signed({1'b0, lin_gain});
		g_ang = $signed({1'b0, ang_gain});
		p_lin = op_lin * g_lin;
		p_ang = op_ang * g_ang;
		// Adding the bias to negative products makes the arithmetic shift round toward zero.
		a_lin = p_lin + (p_lin[PW-1] ? Bias : '0);
		a_ang = p_ang + (p_ang[PW-1] ? Bias : '0);
		q_lin = a_lin >>> (AXIS_BITS - 1);
		q_ang = a_ang >>> (AXIS_BITS - 1);
		lin   = q_lin[VEL_W-1:0];
		ang_t = q_ang[VEL_W-1:0];
		ang   = p_lin[PW-1] ? -ang_t : ang_t;
	end

endmodule

[design/jvcm_checker.sv]
// Port-level assertions for the command mapper and the bind that attaches them.
module jvcm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                tick_valid,
	input logic                                tick_ready,
	input logic                                cmd_valid,
	input logic                                cmd_ready,
	input logic                                cmd_pulse,
	input logic signed [jvcm_pkg::VEL_W-1:0]   cmd_lin
);
	import jvcm_pkg::*;

	logic [1:0] pending_q;
	logic       pulse_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			pulse_seen_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 2'(tick_valid && tick_ready) - 2'(cmd_valid && cmd_ready);
			if (cmd_valid && cmd_ready && cmd_pulse) begin
				pulse_seen_q <= 1'b1;
			end
		end
	end

	// The waypoint goal is issued only once after reset.
	a_pulse_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_pulse |-> !pulse_seen_q)
		else $error("second waypoint pulse");

	// At most two requests are in flight, and a result always has a request behind it.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests in flight");

	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> pending_q != 2'd0)
		else $error("result without a request");

	// The input side stalls only behind a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> cmd_valid && !cmd_ready)
		else $error("input stalled with the output free");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_lin))
		else $error("stalled result changed");

endmodule

bind joystick_velocity_command_mapper jvcm_checker u_jvcm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.tick_valid(tick.valid),
	.tick_ready(tick.ready),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.cmd_pulse(cmd.waypoint_pulse),
	.cmd_lin(cmd.linear_velocity)
);

[verif/tb_top.sv]
// Self-checking testbench for the joystick velocity command mapper: directed table, then random ticks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import jvcm_pkg::*;

	localparam int AXIS_W   = AXIS_BITS_DEF;
	localparam int BTN_W    = NUM_BUTTONS_DEF;
	localparam int HOLD_MAX = (1 << HOLD_COUNT_BITS_DEF) - 1;

	localparam int M_WPT    = 1 << BTN_WAYPOINT;
	localparam int M_LIN_UP = 1 << BTN_LIN_UP;
	localparam int M_ANG_UP = 1 << BTN_ANG_UP;
	localparam int M_LIN_DN = 1 << BTN_LIN_DOWN;
	localparam int M_ANG_DN = 1 << BTN_ANG_DOWN;
	localparam int M_MODE   = 1 << BTN_MODE;
	localparam int M_MUTE   = 1 << BTN_MUTE;

	typedef struct packed {
		logic                     jv;
		logic [BTN_W-1:0]         btn;
		logic signed [AXIS_W-1:0] turn;
		logic signed [AXIS_W-1:0] fwd;
		logic signed [AXIS_W-1:0] tturn;
		logic signed [AXIS_W-1:0] tfwd;
	} tick_t;

	typedef struct packed {
		logic                    pub;
		logic signed [VEL_W-1:0] lin;
		logic signed [VEL_W-1:0] ang;
		logic                    pulse;
		logic                    gyro;
		logic [GAIN_W-1:0]       lg;
		logic [GAIN_W-1:0]       ag;
	} cmd_t;

	typedef struct {
		bit       is_reg;
		cfg_idx_t idx;
		int       val;
		tick_t    t;
		bit       typed;
		cmd_t     want;
	} dir_row_t;

	typedef struct {
		bit prev;
		bit armed;
		bit flag;
		int cnt;
	} hold_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	jvcm_tick_if tick_ch();
	jvcm_cmd_if  cmd_ch();

	joystick_velocity_command_mapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.cmd       (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor copy of the configuration and state, starting from reset values.
	int cfg_toggle  = 20;
	int cfg_wp      = 50;
	int cfg_step    = 1;
	int cfg_lin_max = 200;
	int cfg_ang_max = 2000;

	int     lin_gain = 20;
	int     ang_gain = 20;
	longint last_ang = 0;
	hold_t  mute_h   = '{0, 0, 0, 0};
	hold_t  mode_h   = '{0, 0, 0, 0};
	int     wp_cnt   = 0;
	bit     wp_fired = 0;

	cmd_t pending_cmds[$];
	int   n_fail = 0;
	bit   calm = 0;
	bit   hold_off_req = 0;

	function automatic int step_up(int g, int max);
		return (g + cfg_step > max) ? max : g + cfg_step;
	endfunction

	function automatic int step_down(int g);
		return (g < cfg_step) ? 0 : g - cfg_step;
	endfunction

	// A change of button level arms the qualifier; only an armed, held button counts up.
	function automatic hold_t hold_step(hold_t h, bit btn);
		int c;
		if (h.prev != btn)
			h.armed = 1'b1;
		if (btn) begin
			c = h.cnt + (h.armed ? 1 : 0);
			if (c > cfg_toggle) begin
				h.flag  = !h.flag;
				h.cnt   = 0;
				h.armed = 1'b0;
			end else begin
				h.cnt = (c > HOLD_MAX) ? HOLD_MAX : c;
			end
		end else begin
			h.cnt = 0;
		end
		h.prev = btn;
		return h;
	endfunction

	task automatic map_tick(input tick_t t, output cmd_t c);
		longint num_lin;
		longint num_ang;
		longint lin_v;
		longint ang_v;
		bit     pulse;
		lin_v = 0;
		ang_v = last_ang;
		pulse = 1'b0;
		if (t.jv) begin
			if (t.btn[BTN_LIN_UP])
				lin_gain = step_up(lin_gain, cfg_lin_max);
			else if (t.btn[BTN_LIN_DOWN])
				lin_gain = step_down(lin_gain);
			if (t.btn[BTN_ANG_UP])
				ang_gain = step_up(ang_gain, cfg_ang_max);
			else if (t.btn[BTN_ANG_DOWN])
				ang_gain = step_down(ang_gain);

			// The mode in force is the one held before this tick's toggle.
			if (!mode_h.flag) begin
				num_lin = longint'(t.fwd) * lin_gain;
				num_ang = longint'(t.turn) * ang_gain;
			end else begin
				num_lin = (longint'(1 << (AXIS_W - 2)) - longint'(t.tfwd)) * lin_gain;
				num_ang = -longint'(t.tturn) * ang_gain;
			end
			lin_v = num_lin / (longint'(1) << (AXIS_W - 1));
			ang_v = num_ang / (longint'(1) << (AXIS_W - 1));
			if (num_lin < 0)
				ang_v = -ang_v;
			last_ang = ang_v;

			mute_h = hold_step(mute_h, t.btn[BTN_MUTE]);
			mode_h = hold_step(mode_h, t.btn[BTN_MODE]);

			if (!wp_fired) begin
				if (wp_cnt < cfg_wp) begin
					if (t.btn[BTN_WAYPOINT]) begin
						if (wp_cnt < HOLD_MAX)
							wp_cnt++;
					end else begin
						wp_cnt = 0;
					end
				end else begin
					pulse    = 1'b1;
					wp_fired = 1'b1;
					wp_cnt   = 0;
				end
			end
		end
		c.pub   = !mute_h.flag;
		c.lin   = VEL_W'(lin_v);
		c.ang   = VEL_W'(ang_v);
		c.pulse = pulse;
		c.gyro  = mode_h.flag;
		c.lg    = GAIN_W'(lin_gain);
		c.ag    = GAIN_W'(ang_gain);
	endtask

	function automatic dir_row_t row_tick(bit jv, int btn, int turn, int fwd, int tturn, int tfwd);
		dir_row_t r;
		r.is_reg  = 1'b0;
		r.idx     = CFG_TOGGLE_HOLD;
		r.val     = 0;
		r.t.jv    = jv;
		r.t.btn   = BTN_W'(btn);
		r.t.turn  = AXIS_W'(turn);
		r.t.fwd   = AXIS_W'(fwd);
		r.t.tturn = AXIS_W'(tturn);
		r.t.tfwd  = AXIS_W'(tfwd);
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic dir_row_t row_exp(dir_row_t r, cmd_t w);
		r.typed = 1'b1;
		r.want  = w;
		return r;
	endfunction

	function automatic dir_row_t row_reg(cfg_idx_t idx, int val);
		dir_row_t r;
		r        = row_tick(0, 0, 0, 0, 0, 0);
		r.is_reg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		return r;
	endfunction

	function automatic logic signed [AXIS_W-1:0] rand_axis();
		case ($urandom_range(0, 7))
			0: return AXIS_W'(-32768);
			1: return AXIS_W'(32767);
			2: return '0;
			3: return '1;
			4: return AXIS_W'(16384);
			default: return AXIS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		t.jv    = ($urandom_range(0, 15) != 0);
		t.btn   = BTN_W'($urandom_range(0, (1 << BTN_W) - 1));
		t.turn  = rand_axis();
		t.fwd   = rand_axis();
		t.tturn = rand_axis();
		t.tfwd  = rand_axis();
		return t;
	endfunction

	// Offers one request and holds valid high on return, so back-to-back requests need no gap.
	task automatic send_tick(input tick_t t, input bit typed, input cmd_t want);
		cmd_t c;
		if (!calm && !hold_off_req && $urandom_range(0, 7) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		tick_ch.valid             <= 1'b1;
		tick_ch.joystick_valid    <= t.jv;
		tick_ch.buttons_pressed   <= t.btn;
		tick_ch.axis_turn         <= t.turn;
		tick_ch.axis_forward      <= t.fwd;
		tick_ch.axis_tilt_turn    <= t.tturn;
		tick_ch.axis_tilt_forward <= t.tfwd;
		do @(posedge clk); while (!tick_ch.ready);
		map_tick(t, c);
		pending_cmds.push_back(typed ? want : c);
	endtask

	// Registers change only once the pipeline has drained.
	task automatic write_reg(input cfg_idx_t idx, input int val);
		tick_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TOGGLE_HOLD:   cfg_toggle  = val & 8'hFF;
			CFG_WAYPOINT_HOLD: cfg_wp      = val & 8'hFF;
			CFG_GAIN_STEP:     cfg_step    = val & 7'h7F;
			CFG_LIN_MAX:       cfg_lin_max = val & 12'hFFF;
			CFG_ANG_MAX:       cfg_ang_max = val & 12'hFFF;
			default: ;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Command sink: random stalls, one long hold-off on request, none in the calm tail.
	initial begin
		cmd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				cmd_ch.ready <= 1'b0;
				repeat (100) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				cmd_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				cmd_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_cmd
		cmd_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				$error("command with no request outstanding");
				n_fail++;
			end else begin
				want = pending_cmds.pop_front();
				if (cmd_ch.publish_velocity !== want.pub) begin
					$error("publish_velocity: expected %0d, got %0d", want.pub,
						cmd_ch.publish_velocity);
					n_fail++;
				end
				if (cmd_ch.linear_velocity !== want.lin) begin
					$error("linear_velocity: expected %0d, got %0d", want.lin,
						cmd_ch.linear_velocity);
					n_fail++;
				end
				if (cmd_ch.angular_velocity !== want.ang) begin
					$error("angular_velocity: expected %0d, got %0d", want.ang,
						cmd_ch.angular_velocity);
					n_fail++;
				end
				if (cmd_ch.waypoint_pulse !== want.pulse) begin
					$error("waypoint_pulse: expected %0d, got %0d", want.pulse,
						cmd_ch.waypoint_pulse);
					n_fail++;
				end
				if (cmd_ch.gyro_mode_on !== want.gyro) begin
					$error("gyro_mode_on: expected %0d, got %0d", want.gyro, cmd_ch.gyro_mode_on);
					n_fail++;
				end
				if (cmd_ch.linear_gain_now !== want.lg) begin
					$error("linear_gain_now: expected %0d, got %0d", want.lg,
						cmd_ch.linear_gain_now);
					n_fail++;
				end
				if (cmd_ch.angular_gain_now !== want.ag) begin
					$error("angular_gain_now: expected %0d, got %0d", want.ag,
						cmd_ch.angular_gain_now);
					n_fail++;
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t dir_rows[$];
		tick_t    t;
		int       sent;
		int       len;
		int       held;
		int       pick;

		arst_n                    <= 1'b0;
		cfg_we                    <= 1'b0;
		cfg_index                 <= '0;
		cfg_wdata                 <= '0;
		tick_ch.valid             <= 1'b0;
		tick_ch.joystick_valid    <= 1'b0;
		tick_ch.buttons_pressed   <= '0;
		tick_ch.axis_turn         <= '0;
		tick_ch.axis_forward      <= '0;
		tick_ch.axis_tilt_turn    <= '0;
		tick_ch.axis_tilt_forward <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: full-scale axes, an idle tick and single gain steps.
		dir_rows.push_back(row_exp(row_tick(1, 0, -32768, 32767, 0, 0),
			cmd_t'{1'b1, 14'sd19, -14'sd20, 1'b0, 1'b0, 12'd20, 12'd20}));
		dir_rows.push_back(row_exp(row_tick(0, 8191, 32767, 32767, 32767, 32767),
			cmd_t'{1'b1, 14'sd0, -14'sd20, 1'b0, 1'b0, 12'd20, 12'd20}));
		dir_rows.push_back(row_exp(row_tick(1, M_LIN_UP, 32767, -32768, 0, 0),
			cmd_t'{1'b1, -14'sd21, -14'sd19, 1'b0, 1'b0, 12'd21, 12'd20}));
		dir_rows.push_back(row_exp(row_tick(1, M_LIN_DN | M_ANG_DN, 0, 0, 0, 0),
			cmd_t'{1'b1, 14'sd0, 14'sd0, 1'b0, 1'b0, 12'd20, 12'd19}));
		// Raise wins over lower; a tiny negative product still flips the angular sign.
		dir_rows.push_back(row_tick(1, M_LIN_UP | M_LIN_DN | M_ANG_UP | M_ANG_DN, -1, -1, 0, 0));
		dir_rows.push_back(row_reg(CFG_TOGGLE_HOLD, 1));
		dir_rows.push_back(row_reg(CFG_WAYPOINT_HOLD, 2));
		dir_rows.push_back(row_reg(CFG_GAIN_STEP, 100));
		dir_rows.push_back(row_reg(CFG_LIN_MAX, 4095));
		dir_rows.push_back(row_reg(CFG_ANG_MAX, 4095));
		// Mute toggles on the second held tick, then the disarmed qualifier does nothing.
		repeat (3)
			dir_rows.push_back(row_tick(1, M_MUTE | M_LIN_UP | M_ANG_UP, 12345, -20000, 0, 0));
		dir_rows.push_back(row_tick(1, 0, -7, 7, 0, 0));
		// Mode toggles and the waypoint pulse fires on the tick after its count is reached.
		repeat (3)
			dir_rows.push_back(row_tick(1, M_MODE | M_WPT, -32768, 32767, -32768, -32768));
		dir_rows.push_back(row_tick(1, 0, 0, 0, 32767, 32767));
		dir_rows.push_back(row_tick(1, 0, 0, 0, 0, 16384));
		dir_rows.push_back(row_tick(0, M_MUTE | M_MODE, 1, 1, 1, 1));
		dir_rows.push_back(row_tick(1, M_LIN_DN | M_ANG_DN, 100, 100, -100, 20000));
		repeat (2)
			dir_rows.push_back(row_tick(1, M_MUTE, 500, -500, 32767, -32768));
		// A raise under a lowered maximum clamps straight to it.
		dir_rows.push_back(row_reg(CFG_LIN_MAX, 0));
		dir_rows.push_back(row_tick(1, M_LIN_UP | M_ANG_DN, 32767, 32767, 32767, 32767));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			else
				send_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_TOGGLE_HOLD, 0);
					write_reg(CFG_WAYPOINT_HOLD, 0);
					write_reg(CFG_GAIN_STEP, 1);
					write_reg(CFG_LIN_MAX, 0);
					write_reg(CFG_ANG_MAX, 0);
				end
				1: begin
					write_reg(CFG_TOGGLE_HOLD, 255);
					write_reg(CFG_WAYPOINT_HOLD, 255);
					write_reg(CFG_GAIN_STEP, 100);
					write_reg(CFG_LIN_MAX, 4095);
					write_reg(CFG_ANG_MAX, 4095);
				end
				default: begin
					write_reg(CFG_TOGGLE_HOLD, $urandom_range(0, 6));
					write_reg(CFG_WAYPOINT_HOLD, $urandom_range(0, 255));
					write_reg(CFG_GAIN_STEP, ($urandom_range(0, 3) == 0) ?
						$urandom_range(1, 100) : $urandom_range(1, 8));
					write_reg(CFG_LIN_MAX, $urandom_range(0, 4095));
					write_reg(CFG_ANG_MAX, $urandom_range(0, 4095));
				end
			endcase
			calm = (ph == 5);
			if (ph == 2)
				hold_off_req = 1'b1;
			sent = 0;
			while (sent < 150) begin
				if ($urandom_range(0, 9) < 6) begin
					// Held mute, mode or waypoint button for a random length that can pass the toggle threshold,
					// closed by a release so the next hold is armed again.
					len  = $urandom_range(1, cfg_toggle + 3);
					pick = $urandom_range(0, 3);
					held = (pick == 0) ? M_MUTE : (pick == 1) ? M_MODE :
						(pick == 2) ? M_WPT : (M_MUTE | M_MODE);
					for (int k = 0; k <= len; k++) begin
						t     = rand_tick();
						t.btn = t.btn & ~BTN_W'(M_MUTE | M_MODE | M_WPT);
						if (k < len)
							t.btn = t.btn | BTN_W'(held);
						send_tick(t, 1'b0, '0);
						sent++;
					end
				end else begin
					send_tick(rand_tick(), 1'b0, '0);
					sent++;
				end
			end
		end

		tick_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
